[hw/rtl/dlm_pkg.sv]
// Shared types, constants and helpers of the dense layer multiply-accumulate block.
package dlm_pkg;

  localparam int MAX_INPUTS  = 16;
  localparam int MAX_OUTPUTS = 16;
  localparam int FRAC_BITS   = 8;

  localparam int KIND_W     = 2;
  localparam int SLOT_W     = 8;
  localparam int VAL_W      = 16;
  localparam int NEURON_W   = 4;
  localparam int COUNT_W    = 5;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int WMEM_DEPTH = 256;
  localparam int WADDR_W    = 8;
  localparam int ROW_STRIDE = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BIAS   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ELEM   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_MODE     = 2'd2;

  localparam logic ACT_RELU = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [SLOT_W-1:0]       slot;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic [NEURON_W-1:0]     neuron;
    logic signed [VAL_W-1:0] result;
    logic                    final_res;
  } out_item_t;

  typedef struct packed {
    logic                    valid;
    logic [NEURON_W-1:0]     idx;
    logic                    first;
    logic                    use_prod;
    logic                    emit;
    logic                    final_res;
    logic signed [VAL_W-1:0] x;
  } mac_ctrl_t;

  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c,
                                                     input int maxc);
    logic [COUNT_W-1:0] r;
    if (c == '0) begin
      r = COUNT_W'(1);
    end else if (int'(c) > maxc) begin
      r = COUNT_W'(maxc);
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

[hw/rtl/dense_layer_mac.sv]
// Top level of the dense layer multiply-accumulate block.
// Weight and bias loads leave busy low. An input element holds busy through
// its neuron pass and drain: one shared 16x16 multiplier and adder, with a
// 40-bit accumulator per neuron, handle one neuron per cycle, behind a registered
// weight memory read and a product register. On an element marked last the
// results come out one per cycle, neuron 0 first, each on out_strobe for a
// single cycle; the receiver cannot stall them, so it must take every one.
module dense_layer_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  dlm_pkg::in_item_t                    in_item,
  output logic                                 out_strobe,
  output dlm_pkg::out_item_t                   out_item,
  input  logic                                 cfg_we,
  input  logic [dlm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dlm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [dlm_pkg::COUNT_W-1:0]   input_count_r, output_count_r;
  logic                          act_mode_r;
  logic [dlm_pkg::COUNT_W-1:0]   n_in, n_out;
  logic                          accept, elem_accept, weight_we, bias_we;
  logic [dlm_pkg::WADDR_W-1:0]   raddr;
  logic signed [dlm_pkg::VAL_W-1:0] w_rdata;
  dlm_pkg::mac_ctrl_t            ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_count_r  <= dlm_pkg::COUNT_W'(1);
      output_count_r <= dlm_pkg::COUNT_W'(1);
      act_mode_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dlm_pkg::REG_INPUT_COUNT:  input_count_r  <= cfg_data;
        dlm_pkg::REG_OUTPUT_COUNT: output_count_r <= cfg_data;
        dlm_pkg::REG_ACT_MODE:     act_mode_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign n_in  = dlm_pkg::clamp_count(input_count_r, dlm_pkg::MAX_INPUTS);
  assign n_out = dlm_pkg::clamp_count(output_count_r, dlm_pkg::MAX_OUTPUTS);

  assign accept      = start && !busy;
  assign elem_accept = accept && in_item.kind == dlm_pkg::KIND_ELEM;
  assign weight_we   = accept && in_item.kind == dlm_pkg::KIND_WEIGHT;
  assign bias_we     = accept && in_item.kind == dlm_pkg::KIND_BIAS
                       && in_item.slot < dlm_pkg::SLOT_W'(dlm_pkg::MAX_OUTPUTS);

  dlm_wmem u_wmem (
    .clk   (clk),
    .we    (weight_we),
    .waddr (in_item.slot),
    .wdata (in_item.value),
    .raddr (raddr),
    .rdata (w_rdata)
  );

  dlm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .elem_accept (elem_accept),
    .item        (in_item),
    .n_in        (n_in),
    .n_out       (n_out),
    .busy        (busy),
    .raddr       (raddr),
    .ctrl        (ctrl)
  );

  dlm_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .w_rdata    (w_rdata),
    .bias_we    (bias_we),
    .bias_idx   (in_item.slot[dlm_pkg::NEURON_W-1:0]),
    .bias_wdata (in_item.value),
    .act_mode   (act_mode_r),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

`ifndef NO_ASSERTIONS
  a_elem_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    elem_accept |=> busy)
    else $error("element item did not start the sequencer");

  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.kind != dlm_pkg::KIND_ELEM) |=> !busy)
    else $error("load item raised busy");

  a_strobe_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe outside a neuron pass");
`endif

endmodule

[hw/rtl/dlm_wmem.sv]
// Weight memory: one write port, one registered read port.
module dlm_wmem (
  input  logic                                clk,
  input  logic                                we,
  input  logic [dlm_pkg::WADDR_W-1:0]         waddr,
  input  logic signed [dlm_pkg::VAL_W-1:0]    wdata,
  input  logic [dlm_pkg::WADDR_W-1:0]         raddr,
  output logic signed [dlm_pkg::VAL_W-1:0]    rdata
);

  logic signed [dlm_pkg::VAL_W-1:0] mem [dlm_pkg::WMEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/dlm_seq.sv]
// Sequencer: walks the neurons in use for one input element.
module dlm_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              elem_accept,
  input  dlm_pkg::in_item_t                 item,
  input  logic [dlm_pkg::COUNT_W-1:0]       n_in,
  input  logic [dlm_pkg::COUNT_W-1:0]       n_out,
  output logic                              busy,
  output logic [dlm_pkg::WADDR_W-1:0]       raddr,
  output dlm_pkg::mac_ctrl_t                ctrl
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;

  state_t                            state_r, state_nxt;
  logic [dlm_pkg::NEURON_W-1:0]      idx_r, idx_nxt;
  logic                              drain_r, drain_nxt;
  logic signed [dlm_pkg::VAL_W-1:0]  x_r, x_nxt;
  logic [dlm_pkg::SLOT_W-1:0]        slot_r, slot_nxt;
  logic                              last_r, last_nxt;
  logic                              first_r, first_nxt;
  logic                              use_r, use_nxt;
  logic                              open_r, open_nxt;
  logic                              at_end;

  assign at_end = (dlm_pkg::COUNT_W'(idx_r) + dlm_pkg::COUNT_W'(1)) == n_out;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    drain_nxt = drain_r;
    x_nxt     = x_r;
    slot_nxt  = slot_r;
    last_nxt  = last_r;
    first_nxt = first_r;
    use_nxt   = use_r;
    open_nxt  = open_r;
    case (state_r)
      S_IDLE: begin
        if (elem_accept) begin
          state_nxt = S_RUN;
          idx_nxt   = '0;
          x_nxt     = item.value;
          slot_nxt  = item.slot;
          last_nxt  = item.last;
          first_nxt = !open_r;
          use_nxt   = item.slot < dlm_pkg::SLOT_W'(n_in);
          open_nxt  = !item.last;
        end
      end
      S_RUN: begin
        idx_nxt = idx_r + dlm_pkg::NEURON_W'(1);
        if (at_end) begin
          state_nxt = S_DRAIN;
          drain_nxt = 1'b0;
        end
      end
      S_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      drain_r <= 1'b0;
      open_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      drain_r <= drain_nxt;
      open_r  <= open_nxt;
    end
    x_r     <= x_nxt;
    slot_r  <= slot_nxt;
    last_r  <= last_nxt;
    first_r <= first_nxt;
    use_r   <= use_nxt;
  end

  assign busy  = state_r != S_IDLE;
  assign raddr = dlm_pkg::WADDR_W'(int'(idx_r) * dlm_pkg::ROW_STRIDE) + slot_r;

  always_comb begin
    ctrl.valid     = state_r == S_RUN;
    ctrl.idx       = idx_r;
    ctrl.first     = first_r;
    ctrl.use_prod  = use_r;
    ctrl.emit      = last_r;
    ctrl.final_res = at_end;
    ctrl.x         = x_r;
  end

endmodule

[hw/rtl/dlm_mac.sv]
// Shared multiply-accumulate unit with bias store, accumulators and output formatting.
module dlm_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dlm_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [dlm_pkg::VAL_W-1:0]   w_rdata,
  input  logic                               bias_we,
  input  logic [dlm_pkg::NEURON_W-1:0]       bias_idx,
  input  logic signed [dlm_pkg::VAL_W-1:0]   bias_wdata,
  input  logic                               act_mode,
  output logic                               out_strobe,
  output dlm_pkg::out_item_t                 out_item
);

  localparam logic signed [dlm_pkg::ACC_W-1:0] SAT_HI =
    dlm_pkg::ACC_W'((1 << (dlm_pkg::VAL_W - 1)) - 1);
  localparam logic signed [dlm_pkg::ACC_W-1:0] SAT_LO =
    dlm_pkg::ACC_W'(-(1 << (dlm_pkg::VAL_W - 1)));

  dlm_pkg::mac_ctrl_t                  c1_r, c2_r;
  logic signed [dlm_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [dlm_pkg::ACC_W-1:0]    acc_r [dlm_pkg::MAX_OUTPUTS];
  logic signed [dlm_pkg::VAL_W-1:0]    bias_r [dlm_pkg::MAX_OUTPUTS];
  logic signed [dlm_pkg::ACC_W-1:0]    base, addend, sum, shifted;
  logic signed [dlm_pkg::VAL_W-1:0]    res;
  logic                                out_strobe_r;
  dlm_pkg::out_item_t                  out_item_r;

  assign prod_nxt = w_rdata * c1_r.x;

  always_comb begin
    if (c2_r.first) begin
      base = dlm_pkg::ACC_W'(bias_r[c2_r.idx]) <<< dlm_pkg::FRAC_BITS;
    end else begin
      base = acc_r[c2_r.idx];
    end
    addend  = c2_r.use_prod ? dlm_pkg::ACC_W'(prod_r) : '0;
    sum     = base + addend;
    shifted = sum >>> dlm_pkg::FRAC_BITS;
    if (shifted > SAT_HI) begin
      res = dlm_pkg::VAL_W'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      res = dlm_pkg::VAL_W'(SAT_LO);
    end else begin
      res = dlm_pkg::VAL_W'(shifted);
    end
    if (act_mode == dlm_pkg::ACT_RELU && res < 0) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (bias_we) begin
      bias_r[bias_idx] <= bias_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r         <= '0;
      c2_r         <= '0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < dlm_pkg::MAX_OUTPUTS; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      c1_r         <= ctrl;
      c2_r         <= c1_r;
      out_strobe_r <= c2_r.valid && c2_r.emit;
      if (c2_r.valid) begin
        acc_r[c2_r.idx] <= sum;
      end
    end
    prod_r                <= prod_nxt;
    out_item_r.neuron     <= c2_r.idx;
    out_item_r.result     <= res;
    out_item_r.final_res  <= c2_r.final_res;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the dense layer multiply-accumulate block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dlm_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int SETTLE = dlm_pkg::MAX_OUTPUTS + 8;
  localparam int RANDOM_ITEMS = 70;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PLAN_ROWS = 26;

  typedef struct {
    bit                            is_reg;
    logic [dlm_pkg::CFG_IDX_W-1:0] ridx;
    logic [4:0]                    rval;
    logic [dlm_pkg::KIND_W-1:0]    kind;
    logic [dlm_pkg::SLOT_W-1:0]    slot;
    logic [dlm_pkg::VAL_W-1:0]     value;
    logic                          last;
    bit                            has_exp;
    logic [dlm_pkg::VAL_W-1:0]     exp_val;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  dlm_pkg::in_item_t in_item = '0;
  logic out_strobe;
  dlm_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [dlm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dlm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic signed [dlm_pkg::VAL_W-1:0] wmem [dlm_pkg::WMEM_DEPTH];
  logic signed [dlm_pkg::VAL_W-1:0] bmem [dlm_pkg::MAX_OUTPUTS];
  bit w_set [dlm_pkg::WMEM_DEPTH];
  bit b_set [dlm_pkg::MAX_OUTPUTS];
  logic signed [dlm_pkg::ACC_W-1:0] acc [dlm_pkg::MAX_OUTPUTS];
  bit vec_open = 1'b0;
  logic [4:0] set_inputs = 5'd1;
  logic [4:0] set_outputs = 5'd1;
  logic set_act = 1'b0;

  dlm_pkg::out_item_t due_results [$];
  dlm_pkg::out_item_t want;
  int err_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int rnd_items = 0;
  int phases = 0;
  int cycles = 0;
  bit steady = 1'b0;

  step_t plan [PLAN_ROWS] = '{
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_WEIGHT, 8'd0, 16'h0100, 1'b0, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_BIAS, 8'd0, 16'h0000, 1'b0, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_ELEM, 8'd0, 16'h0200, 1'b1, 1, 16'h0200},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_BIAS, 8'd0, 16'h0100, 1'b0, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_ELEM, 8'd0, 16'h0000, 1'b1, 1, 16'h0100},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_WEIGHT, 8'd0, 16'h7FFF, 1'b0, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_ELEM, 8'd0, 16'h7FFF, 1'b1, 1, 16'h7FFF},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_ELEM, 8'd0, 16'h8000, 1'b1, 1, 16'h8000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_WEIGHT, 8'd255, 16'hFFFF, 1'b0, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_BIAS, 8'd255, 16'h1234, 1'b1, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_BIAS, 8'd16, 16'h8000, 1'b0, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, KIND_NONE, 8'd255, 16'hFFFF, 1'b1, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_WEIGHT, 8'd0, 16'h0100, 1'b1, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_ELEM, 8'd5, 16'h7FFF, 1'b0, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_ELEM, 8'd0, 16'h0300, 1'b1, 1, 16'h0400},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_ELEM, 8'd31, 16'h8000, 1'b1, 1, 16'h0100},
    '{1, dlm_pkg::REG_ACT_MODE, 5'd1, KIND_NONE, 8'd0, 16'h0000, 1'b0, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_BIAS, 8'd0, 16'hFF00, 1'b0, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_ELEM, 8'd0, 16'h0000, 1'b1, 1, 16'h0000},
    '{1, dlm_pkg::REG_INPUT_COUNT, 5'd0, KIND_NONE, 8'd0, 16'h0000, 1'b0, 0, 16'h0000},
    '{1, dlm_pkg::REG_OUTPUT_COUNT, 5'd0, KIND_NONE, 8'd0, 16'h0000, 1'b0, 0, 16'h0000},
    '{1, dlm_pkg::REG_ACT_MODE, 5'd0, KIND_NONE, 8'd0, 16'h0000, 1'b0, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_BIAS, 8'd0, 16'h0000, 1'b0, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_WEIGHT, 8'd0, 16'h0001, 1'b0, 0, 16'h0000},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_ELEM, 8'd0, 16'hFFFF, 1'b1, 1, 16'hFFFF},
    '{0, dlm_pkg::REG_INPUT_COUNT, 5'd0, dlm_pkg::KIND_ELEM, 8'd0, 16'h7FFF, 1'b1, 1, 16'h007F}
  };

  dense_layer_mac dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycles, due_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int eff_count(input logic [4:0] c, input int maxc);
    if (c == 5'd0) return 1;
    if (int'(c) > maxc) return maxc;
    return int'(c);
  endfunction

  function automatic logic [dlm_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_err(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      results_seen++;
      if (due_results.size() == 0) begin
        report_err($sformatf("unexpected result neuron %0d value %h final %b",
                             out_item.neuron, out_item.result, out_item.final_res));
      end else begin
        want = due_results.pop_front();
        if (out_item.neuron !== want.neuron || out_item.result !== want.result ||
            out_item.final_res !== want.final_res)
          report_err($sformatf("result got n%0d/%h/f%b want n%0d/%h/f%b",
                               out_item.neuron, out_item.result, out_item.final_res,
                               want.neuron, want.result, want.final_res));
      end
    end
  end

  task automatic layer_step(input dlm_pkg::in_item_t it, input bit fixed,
                            input logic [dlm_pkg::VAL_W-1:0] fixed_val);
    int i;
    int n_out;
    int n_in;
    logic [dlm_pkg::WADDR_W-1:0] addr;
    logic signed [dlm_pkg::PROD_W-1:0] prod;
    logic signed [dlm_pkg::ACC_W-1:0] q;
    logic signed [dlm_pkg::VAL_W-1:0] r;
    dlm_pkg::out_item_t o;
    n_out = eff_count(set_outputs, dlm_pkg::MAX_OUTPUTS);
    n_in = eff_count(set_inputs, dlm_pkg::MAX_INPUTS);
    case (it.kind)
      dlm_pkg::KIND_WEIGHT: begin
        wmem[it.slot] = it.value;
        w_set[it.slot] = 1'b1;
      end
      dlm_pkg::KIND_BIAS: begin
        if (int'(it.slot) < dlm_pkg::MAX_OUTPUTS) begin
          bmem[it.slot[dlm_pkg::NEURON_W-1:0]] = it.value;
          b_set[it.slot[dlm_pkg::NEURON_W-1:0]] = 1'b1;
        end
      end
      dlm_pkg::KIND_ELEM: begin
        if (!vec_open) begin
          for (i = 0; i < n_out; i++)
            acc[i] = {{16{bmem[i][dlm_pkg::VAL_W-1]}}, bmem[i], 8'h00};
          vec_open = 1'b1;
        end
        if (int'(it.slot) < n_in) begin
          for (i = 0; i < n_out; i++) begin
            addr = dlm_pkg::WADDR_W'(i * dlm_pkg::ROW_STRIDE + int'(it.slot));
            prod = $signed(wmem[addr]) * $signed(it.value);
            acc[i] = acc[i] + {{8{prod[dlm_pkg::PROD_W-1]}}, prod};
          end
        end
        if (it.last) begin
          for (i = 0; i < n_out; i++) begin
            q = acc[i] >>> dlm_pkg::FRAC_BITS;
            if (q > 40'sd32767) r = 16'sh7FFF;
            else if (q < -40'sd32768) r = 16'sh8000;
            else r = q[dlm_pkg::VAL_W-1:0];
            if (set_act == dlm_pkg::ACT_RELU && r < 0) r = '0;
            if (fixed) r = fixed_val;
            o.neuron = dlm_pkg::NEURON_W'(i);
            o.result = r;
            o.final_res = (i == n_out - 1);
            due_results.push_back(o);
          end
          vec_open = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [dlm_pkg::KIND_W-1:0] kind,
                           input logic [dlm_pkg::SLOT_W-1:0] slot,
                           input logic [dlm_pkg::VAL_W-1:0] value, input logic last,
                           input bit fixed = 1'b0,
                           input logic [dlm_pkg::VAL_W-1:0] fixed_val = '0);
    dlm_pkg::in_item_t it;
    it.kind = kind;
    it.slot = slot;
    it.value = value;
    it.last = last;
    while (!steady && $urandom_range(0, 99) < 17) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    in_item = it;
    start = 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    layer_step(it, fixed, fixed_val);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dlm_pkg::CFG_IDX_W-1:0] idx, input logic [4:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    case (idx)
      dlm_pkg::REG_INPUT_COUNT: set_inputs = data;
      dlm_pkg::REG_OUTPUT_COUNT: set_outputs = data;
      dlm_pkg::REG_ACT_MODE: set_act = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // load any weight or bias that the next element would read before it was written
  task automatic cover_reads(input logic [dlm_pkg::SLOT_W-1:0] slot);
    int i;
    int n_out;
    logic [dlm_pkg::WADDR_W-1:0] addr;
    n_out = eff_count(set_outputs, dlm_pkg::MAX_OUTPUTS);
    for (i = 0; i < n_out; i++) begin
      if (!vec_open && !b_set[i])
        send_item(dlm_pkg::KIND_BIAS, dlm_pkg::SLOT_W'(i), pick_value(), 1'b0);
      addr = dlm_pkg::WADDR_W'(i * dlm_pkg::ROW_STRIDE + int'(slot));
      if (int'(slot) < eff_count(set_inputs, dlm_pkg::MAX_INPUTS) && !w_set[addr])
        send_item(dlm_pkg::KIND_WEIGHT, addr, pick_value(), 1'b0);
    end
  endtask

  initial begin
    int row;
    int v;
    int k;
    int n_vec;
    int n_in;
    int len;
    bit full;
    logic [4:0] ni;
    logic [4:0] no;
    logic am;
    logic [dlm_pkg::SLOT_W-1:0] slot;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (row = 0; row < PLAN_ROWS; row++) begin
      if (plan[row].is_reg) begin
        drain();
        write_reg(plan[row].ridx, plan[row].rval);
      end else begin
        send_item(plan[row].kind, plan[row].slot, plan[row].value, plan[row].last,
                  plan[row].has_exp, plan[row].exp_val);
      end
    end

    while (rnd_items < RANDOM_ITEMS) begin
      case (phases)
        0: begin
          ni = 5'd16;
          no = 5'd16;
          am = 1'b1;
        end
        1: begin
          ni = 5'd31;
          no = 5'd31;
          am = 1'b0;
        end
        default: begin
          ni = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6));
          no = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6));
          am = 1'($urandom);
        end
      endcase
      drain();
      write_reg(dlm_pkg::REG_INPUT_COUNT, ni);
      write_reg(dlm_pkg::REG_OUTPUT_COUNT, no);
      write_reg(dlm_pkg::REG_ACT_MODE, {4'b0, am});
      phases++;
      n_vec = $urandom_range(2, 5);
      for (v = 0; v < n_vec && rnd_items < RANDOM_ITEMS; v++) begin
        n_in = eff_count(set_inputs, dlm_pkg::MAX_INPUTS);
        full = (n_in <= 8) && ($urandom_range(0, 2) == 0);
        len = full ? n_in : $urandom_range(1, (n_in < 4) ? n_in : 4);
        for (k = 0; k < len; k++) begin
          steady = (rnd_items >= 20 && rnd_items < 50);
          if ($urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 4))
              0: send_item(KIND_NONE, 8'($urandom), pick_value(), 1'($urandom));
              1: send_item(dlm_pkg::KIND_BIAS, 8'($urandom_range(dlm_pkg::MAX_OUTPUTS, 255)),
                           pick_value(), 1'($urandom));
              2: begin
                send_item(dlm_pkg::KIND_WEIGHT, 8'($urandom), pick_value(), 1'($urandom));
                rnd_items++;
              end
              3: begin
                send_item(dlm_pkg::KIND_BIAS, 8'($urandom_range(0, dlm_pkg::MAX_OUTPUTS - 1)),
                          pick_value(), 1'($urandom));
                rnd_items++;
              end
              default: begin
                slot = 8'($urandom_range(n_in, 255));
                cover_reads(slot);
                send_item(dlm_pkg::KIND_ELEM, slot, pick_value(), $urandom_range(0, 3) == 0);
                rnd_items++;
              end
            endcase
          end
          if (full) begin
            slot = dlm_pkg::SLOT_W'(k);
          end else if (eff_count(set_outputs, dlm_pkg::MAX_OUTPUTS) > 8) begin
            slot = ($urandom_range(0, 1) == 0) ? '0 : dlm_pkg::SLOT_W'(n_in - 1);
          end else begin
            slot = dlm_pkg::SLOT_W'($urandom_range(0, n_in - 1));
          end
          cover_reads(slot);
          send_item(dlm_pkg::KIND_ELEM, slot, pick_value(), k == len - 1);
          rnd_items++;
        end
        if ($urandom_range(0, 5) == 0) drain();
      end
    end

    steady = 1'b0;
    drain();
    $display("Sent %0d items (%0d random) over %0d layer settings; %0d results checked.",
             items_sent, rnd_items, phases, results_seen);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
